### hdl/rbb_pkg.sv
// Shared types, register codes and constants for the 3x3 RGB box blur.
// Used by every module of the block but rbb_ram; depends on nothing.
package rbb_pkg;

	localparam int PIX_W      = 24;
	localparam int CHAN_W     = 8;
	localparam int SUM_W      = 12;
	localparam int ENTRY_W    = 2 * PIX_W;
	localparam int CFG_DATA_W = 16;
	localparam int WIDTH_W    = 12;
	localparam int HEIGHT_W   = 16;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

	// floor(s / 9) == (s * 3641) >> 15 for every s below 32768
	localparam logic [SUM_W-1:0]  MEAN_RECIP = 12'd3641;
	localparam int                MEAN_SHIFT = 15;
	localparam logic [CHAN_W-1:0] PIX_MAX    = 8'hff;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic              cmd;
		logic              frame_start;
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] blue_out;
		logic              filtered;
		logic              frame_end;
	} out_item_t;

	// What the counters decided for one item
	typedef struct packed {
		logic emit;
		logic interior;
		logic last;
	} tag_t;

	typedef struct packed {
		tag_t tag;
		pix_t pix;
	} s1_item_t;

	typedef struct packed {
		logic [SUM_W-1:0] red;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] blue;
	} sum_t;

	typedef struct packed {
		logic interior;
		logic last;
		sum_t sum;
		pix_t center;
	} s2_item_t;

	// Truncated mean of nine channel values, clamped to the pixel range
	function automatic logic [CHAN_W-1:0] mean9(input logic [SUM_W-1:0] s);
		logic [2*SUM_W-1:0] prod;
		logic [2*SUM_W-MEAN_SHIFT-1:0] q;
		prod = {{SUM_W{1'b0}}, s} * {{SUM_W{1'b0}}, MEAN_RECIP};
		q = prod[2*SUM_W-1:MEAN_SHIFT];
		if (q > (2*SUM_W-MEAN_SHIFT)'(PIX_MAX)) begin
			return PIX_MAX;
		end
		return q[CHAN_W-1:0];
	endfunction

endpackage

### hdl/rgb_box_blur_3x3.sv
// Top level of the 3x3 RGB box blur: counters, row store, window, divider.
// Depends on rbb_pkg, rbb_ctrl, rbb_ram, rbb_window and rbb_mean.
//
//  channel  direction  handshake              payload
//  cfg      in         cfg_we                 cfg_index, cfg_data
//  in       in         in_valid / in_stall    in_data (rbb_pkg::in_item_t)
//  out      out        out_valid / out_stall  out_data (rbb_pkg::out_item_t)
//
// One item is accepted per clock while in_stall is low.
// Results trail the input by image_width+1 items (row store of two rows).
// Reset clears counters, window and valid bits; the row store is not cleared.
// out_stall holds the output register; stage 2 and stage 1 fill behind it
// before in_stall rises. Items that give no result never wait on the output.
module rgb_box_blur_3x3 #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  rbb_pkg::cfg_reg_t              cfg_index,
	input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  rbb_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output rbb_pkg::out_item_t             out_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic                        rd_en;
	logic [COL_W-1:0]            rd_addr;
	logic                        valid_s1;
	logic [COL_W-1:0]            addr_s1;
	rbb_pkg::s1_item_t           item_s1;
	logic                        s1_go;
	logic                        ram_we;
	logic [COL_W-1:0]            ram_waddr;
	logic [rbb_pkg::ENTRY_W-1:0] ram_wdata;
	logic [rbb_pkg::ENTRY_W-1:0] ram_rdata;
	logic                        valid_s2;
	rbb_pkg::s2_item_t           item_s2;
	logic                        s2_ready;

	rbb_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.s1_go     (s1_go),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.valid_s1  (valid_s1),
		.addr_s1   (addr_s1),
		.item_s1   (item_s1)
	);

	// Two earlier rows per column
	rbb_ram #(
		.WIDTH (rbb_pkg::ENTRY_W),
		.DEPTH (MAX_WIDTH)
	) u_row_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	rbb_window #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.valid_s1  (valid_s1),
		.addr_s1   (addr_s1),
		.item_s1   (item_s1),
		.s1_go     (s1_go),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata),
		.s2_ready  (s2_ready),
		.valid_s2  (valid_s2),
		.item_s2   (item_s2)
	);

	rbb_mean u_mean (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.item_s2   (item_s2),
		.s2_ready  (s2_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### hdl/rbb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read during a write to the same address returns the old contents.
// No dependencies.
module rbb_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/rbb_ctrl.sv
// Configuration registers, frame position counters and the row store read.
// Decides per item whether and how a result is produced. Uses rbb_pkg.
module rbb_ctrl #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  rbb_pkg::cfg_reg_t                 cfg_index,
	input  logic [rbb_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  rbb_pkg::in_item_t                 in_data,
	input  logic                              s1_go,
	output logic                              rd_en,
	output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr,
	output logic                              valid_s1,
	output logic [$clog2(MAX_WIDTH)-1:0]      addr_s1,
	output rbb_pkg::s1_item_t                 item_s1
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CNT_W = $clog2(MAX_WIDTH + 2);
	localparam int ROW_W = rbb_pkg::HEIGHT_W;

	logic [rbb_pkg::WIDTH_W-1:0] width_q;
	logic [ROW_W-1:0]            height_q;
	logic [COL_W-1:0]            in_col_q;
	logic [COL_W-1:0]            out_col_q;
	logic [ROW_W-1:0]            out_row_q;
	logic [CNT_W-1:0]            fill_q;

	logic [CNT_W-1:0] w;
	logic [CNT_W-1:0] ic0, ic1, ic_inc, ic_nxt;
	logic [CNT_W-1:0] oc0, oc1, oc_inc, oc_nxt;
	logic [CNT_W-1:0] fc0, fc_nxt;
	logic [ROW_W-1:0] or0, or1, or_nxt;
	logic [ROW_W:0]   or1_inc;
	logic             fill_full, emit, interior, last;
	logic             accept;
	rbb_pkg::pix_t    pix;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rbb_pkg::WIDTH_RESET;
			height_q <= rbb_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rbb_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[rbb_pkg::WIDTH_W-1:0];
				rbb_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective width: zero acts as one, large values are capped
	always_comb begin
		if (width_q == '0) begin
			w = CNT_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w = CNT_W'(MAX_WIDTH);
		end else begin
			w = CNT_W'(width_q);
		end
	end

	// Position of this item, with frame restart and wrap after a width change
	always_comb begin
		ic0 = in_data.frame_start ? '0 : CNT_W'(in_col_q);
		oc0 = in_data.frame_start ? '0 : CNT_W'(out_col_q);
		or0 = in_data.frame_start ? '0 : out_row_q;
		fc0 = in_data.frame_start ? '0 : fill_q;

		ic1 = (ic0 >= w) ? '0 : ic0;
		ic_inc = ic1 + 1'b1;
		ic_nxt = (ic_inc >= w) ? '0 : ic_inc;

		oc1 = (oc0 >= w) ? '0 : oc0;
		or1 = ((oc0 >= w) && (or0 < height_q)) ? or0 + 1'b1 : or0;
		oc_inc = oc1 + 1'b1;
		or1_inc = {1'b0, or1} + 1'b1;

		fill_full = fc0 >= (w + 1'b1);
		fc_nxt = fill_full ? fc0 : fc0 + 1'b1;
		emit = fill_full && (or1 < height_q);

		interior = emit && (or1 != '0) && (or1_inc < {1'b0, height_q})
			&& (oc1 != '0) && (oc_inc < w);
		last = emit && (or1_inc == {1'b0, height_q}) && (oc_inc == w);

		if (emit) begin
			oc_nxt = (oc_inc >= w) ? '0 : oc_inc;
			or_nxt = (oc_inc >= w) ? or1_inc[ROW_W-1:0] : or1;
		end else begin
			oc_nxt = oc1;
			or_nxt = or1;
		end

		pix = in_data.cmd ? '0 : {in_data.red_in, in_data.green_in, in_data.blue_in};
	end

	// Input handshake: take an item whenever stage 1 is free or draining
	assign in_stall = valid_s1 && !s1_go;
	assign accept   = in_valid && !in_stall;
	assign rd_en    = accept;
	assign rd_addr  = ic1[COL_W-1:0];

	// Counters and stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			fill_q    <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (accept) begin
				in_col_q  <= ic_nxt[COL_W-1:0];
				out_col_q <= oc_nxt[COL_W-1:0];
				out_row_q <= or_nxt;
				fill_q    <= fc_nxt;
			end
			valid_s1 <= accept || (valid_s1 && !s1_go);
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1               <= ic1[COL_W-1:0];
			item_s1.pix           <= pix;
			item_s1.tag.emit      <= emit;
			item_s1.tag.interior  <= interior;
			item_s1.tag.last      <= last;
		end
	end

	// A held item keeps its row store address and payload
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_go |=> valid_s1 && $stable(addr_s1) && $stable(item_s1))
		else $error("stage 1 item changed while held");

	// An averaged pixel is never the last pixel of a frame
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.tag.interior |-> item_s1.tag.emit && !item_s1.tag.last)
		else $error("interior tag on a non-result or last item");

endmodule

### hdl/rbb_window.sv
// 3x3 window registers, row store write-back with read forwarding,
// and the per-channel neighborhood sums. Uses rbb_pkg.
module rbb_window #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]      rd_addr,
	input  logic                              valid_s1,
	input  logic [$clog2(MAX_WIDTH)-1:0]      addr_s1,
	input  rbb_pkg::s1_item_t                 item_s1,
	output logic                              s1_go,
	output logic                              ram_we,
	output logic [$clog2(MAX_WIDTH)-1:0]      ram_waddr,
	output logic [rbb_pkg::ENTRY_W-1:0]       ram_wdata,
	input  logic [rbb_pkg::ENTRY_W-1:0]       ram_rdata,
	input  logic                              s2_ready,
	output logic                              valid_s2,
	output rbb_pkg::s2_item_t                 item_s2
);

	localparam int PW = rbb_pkg::PIX_W;

	rbb_pkg::pix_t                 win_q [3][3];
	logic                          fwd_q;
	logic [rbb_pkg::ENTRY_W-1:0]   fwd_data_q;
	logic [rbb_pkg::ENTRY_W-1:0]   entry;
	rbb_pkg::pix_t                 above2, above1;
	logic                          leave;
	rbb_pkg::sum_t                 c0, c1, c2, total;

	function automatic rbb_pkg::sum_t col_sum(input rbb_pkg::pix_t t,
		input rbb_pkg::pix_t m, input rbb_pkg::pix_t b);
		rbb_pkg::sum_t s;
		s.red   = rbb_pkg::SUM_W'(t[23:16]) + rbb_pkg::SUM_W'(m[23:16])
			+ rbb_pkg::SUM_W'(b[23:16]);
		s.green = rbb_pkg::SUM_W'(t[15:8]) + rbb_pkg::SUM_W'(m[15:8])
			+ rbb_pkg::SUM_W'(b[15:8]);
		s.blue  = rbb_pkg::SUM_W'(t[7:0]) + rbb_pkg::SUM_W'(m[7:0])
			+ rbb_pkg::SUM_W'(b[7:0]);
		return s;
	endfunction

	// Row store entry: forwarded when it was written in the cycle of the read
	assign entry  = fwd_q ? fwd_data_q : ram_rdata;
	assign above2 = entry[2*PW-1:PW];
	assign above1 = entry[PW-1:0];

	// Stage 1 retires unless its result has nowhere to go
	assign s1_go = !item_s1.tag.emit || !valid_s2 || s2_ready;
	assign leave = valid_s1 && s1_go;

	// Write back: the middle row moves up, the new pixel becomes the middle row
	assign ram_we    = leave;
	assign ram_waddr = addr_s1;
	assign ram_wdata = {above1, item_s1.pix};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= ram_we && (ram_waddr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= ram_wdata;
		end
	end

	// Window shift: [column oldest..newest][row top..bottom]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[c][r] <= '0;
				end
			end
		end else if (leave) begin
			win_q[0]    <= win_q[1];
			win_q[1]    <= win_q[2];
			win_q[2][0] <= above2;
			win_q[2][1] <= above1;
			win_q[2][2] <= item_s1.pix;
		end
	end

	// Sums over the shifted window
	always_comb begin
		c0 = col_sum(win_q[1][0], win_q[1][1], win_q[1][2]);
		c1 = col_sum(win_q[2][0], win_q[2][1], win_q[2][2]);
		c2 = col_sum(above2, above1, item_s1.pix);
		total.red   = c0.red + c1.red + c2.red;
		total.green = c0.green + c1.green + c2.green;
		total.blue  = c0.blue + c1.blue + c2.blue;
	end

	// Stage 2: only items with a result enter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= (leave && item_s1.tag.emit) || (valid_s2 && !s2_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (leave && item_s1.tag.emit) begin
			item_s2.interior <= item_s1.tag.interior;
			item_s2.last     <= item_s1.tag.last;
			item_s2.sum      <= total;
			item_s2.center   <= win_q[2][1];
		end
	end

	// Same-entry write and read in one cycle must select the forwarded data
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && ram_we && (ram_waddr == rd_addr) |=> fwd_q)
		else $error("row store forwarding missed");

	// A waiting stage 2 item is held intact
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !s2_ready |=> valid_s2 && $stable(item_s2))
		else $error("stage 2 item changed while held");

endmodule

### hdl/rbb_mean.sv
// Divide-by-nine of the channel sums and the output register.
// Border items pass their center pixel. Uses rbb_pkg.
module rbb_mean (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s2,
	input  rbb_pkg::s2_item_t    item_s2,
	output logic                 s2_ready,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rbb_pkg::out_item_t   out_data
);

	logic               out_valid_q;
	rbb_pkg::out_item_t out_data_q;
	logic               load;

	assign s2_ready = !out_valid_q || !out_stall;
	assign load     = valid_s2 && s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load || (out_valid_q && out_stall);
		end
	end

	// Result selection: mean for interior pixels, center pixel otherwise
	always_ff @(posedge clk) begin
		if (load) begin
			if (item_s2.interior) begin
				out_data_q.red_out   <= rbb_pkg::mean9(item_s2.sum.red);
				out_data_q.green_out <= rbb_pkg::mean9(item_s2.sum.green);
				out_data_q.blue_out  <= rbb_pkg::mean9(item_s2.sum.blue);
			end else begin
				out_data_q.red_out   <= item_s2.center[23:16];
				out_data_q.green_out <= item_s2.center[15:8];
				out_data_q.blue_out  <= item_s2.center[7:0];
			end
			out_data_q.filtered  <= item_s2.interior;
			out_data_q.frame_end <= item_s2.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A result appears only after a stage 2 item was there to load it
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s2))
		else $error("result without a stage 2 item");

endmodule

### test/rgb_box_blur_3x3_tb.sv
// Self-checking testbench for the 3x3 RGB box blur (rgb_box_blur_3x3).
// Predicts each output pixel from the accepted input items; depends on rbb_pkg and the RTL.
`timescale 1ns / 1ps

module rgb_box_blur_3x3_tb;

	localparam int MAX_W         = 2048;
	localparam int WINDOW_PIXELS = 9;
	localparam int DRAIN_CYCLES  = 8;
	localparam int QUIET_LIMIT   = 3000;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef enum int {
		PAT_RANDOM,
		PAT_MAX,
		PAT_ALT
	} pattern_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	rbb_pkg::cfg_reg_t              cfg_index = rbb_pkg::REG_IMAGE_WIDTH;
	logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_stall;
	rbb_pkg::in_item_t              in_data   = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	rbb_pkg::out_item_t             out_data;

	// Idling controls shared by the sender, the receiver and the tests
	int sender_idle_pct = 0;
	int stall_pct       = 0;
	int hold_left       = 0;

	int items_sent     = 0;
	int results_seen   = 0;
	int mismatch_count = 0;
	int quiet_cycles   = 0;

	// Predictor state
	logic [rbb_pkg::WIDTH_W-1:0]  cfg_width  = rbb_pkg::WIDTH_RESET;
	logic [rbb_pkg::HEIGHT_W-1:0] cfg_height = rbb_pkg::HEIGHT_RESET;
	logic [rbb_pkg::ENTRY_W-1:0]  line_mem [0:MAX_W-1];
	rbb_pkg::pix_t                win [0:2][0:2];   // [column oldest..newest][row top..bottom]
	int unsigned                  in_col   = 0;
	logic [15:0]                  in_row   = '0;
	int unsigned                  out_col  = 0;
	int unsigned                  out_row  = 0;
	int unsigned                  fill_cnt = 0;
	rbb_pkg::out_item_t           pending_pixels [$];
	rbb_pkg::out_item_t           want;

	rgb_box_blur_3x3 #(
		.MAX_WIDTH(MAX_W)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #6 clk = ~clk;

	// Per-channel truncated mean over the current window
	function automatic logic [rbb_pkg::CHAN_W-1:0] window_mean(input int sh);
		int unsigned total;
		total = 0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				total += (win[c][r] >> sh) & rbb_pkg::PIX_MAX;
			end
		end
		total = total / WINDOW_PIXELS;
		return (total > rbb_pkg::PIX_MAX) ? rbb_pkg::PIX_MAX : total[rbb_pkg::CHAN_W-1:0];
	endfunction

	// Advance the predictor by one accepted item; queue the pixel it releases, if any
	function automatic void advance_blur(input rbb_pkg::in_item_t it);
		int unsigned                 w;
		int unsigned                 h;
		rbb_pkg::pix_t               px;
		rbb_pkg::pix_t               center;
		logic [rbb_pkg::ENTRY_W-1:0] entry;
		logic                        interior;
		rbb_pkg::out_item_t          res;
		w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
		h = cfg_height;
		if (it.frame_start) begin
			in_col   = 0;
			in_row   = '0;
			out_col  = 0;
			out_row  = 0;
			fill_cnt = 0;
		end
		// counters left beyond a shrunken width wrap first
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (out_col >= w) begin
			out_col = 0;
			if (out_row < h) out_row++;
		end
		px     = (it.cmd == CMD_FLUSH) ? '0 : {it.red_in, it.green_in, it.blue_in};
		entry  = line_mem[in_col];
		center = win[2][1];
		for (int c = 0; c < 2; c++) begin
			for (int r = 0; r < 3; r++) begin
				win[c][r] = win[c+1][r];
			end
		end
		win[2][0] = entry[rbb_pkg::ENTRY_W-1:rbb_pkg::PIX_W];
		win[2][1] = entry[rbb_pkg::PIX_W-1:0];
		win[2][2] = px;
		line_mem[in_col] = {entry[rbb_pkg::PIX_W-1:0], px};
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		// line delay still filling, or frame already finished
		if (fill_cnt < w + 1) begin
			fill_cnt++;
			return;
		end
		if (out_row >= h) return;
		interior = out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w;
		if (interior) begin
			res.red_out   = window_mean(16);
			res.green_out = window_mean(8);
			res.blue_out  = window_mean(0);
		end else begin
			res.red_out   = center[23:16];
			res.green_out = center[15:8];
			res.blue_out  = center[7:0];
		end
		res.filtered  = interior;
		res.frame_end = (out_row + 1 == h) && (out_col + 1 == w);
		pending_pixels.push_back(res);
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
		end
	endfunction

	function automatic logic [rbb_pkg::CHAN_W-1:0] random_channel();
		if ($urandom_range(3) == 0) return $urandom_range(1) ? rbb_pkg::PIX_MAX : '0;
		return rbb_pkg::CHAN_W'($urandom_range(255));
	endfunction

	function automatic rbb_pkg::in_item_t make_pixel(input pattern_t pat, input int idx);
		rbb_pkg::in_item_t it;
		it.cmd         = CMD_PIXEL;
		it.frame_start = 1'b0;
		case (pat)
			PAT_MAX: begin
				it.red_in   = rbb_pkg::PIX_MAX;
				it.green_in = rbb_pkg::PIX_MAX;
				it.blue_in  = rbb_pkg::PIX_MAX;
			end
			PAT_ALT: begin
				it.red_in   = idx[0] ? rbb_pkg::PIX_MAX : '0;
				it.green_in = idx[0] ? '0 : rbb_pkg::PIX_MAX;
				it.blue_in  = idx[1] ? rbb_pkg::PIX_MAX : '0;
			end
			default: begin
				it.red_in   = random_channel();
				it.green_in = random_channel();
				it.blue_in  = random_channel();
			end
		endcase
		return it;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("%0t ns: result %0d: %s", $time, results_seen, what);
	endtask

	// Offer one item, holding it until accepted
	task automatic send_item(input rbb_pkg::in_item_t it);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		advance_blur(it);
	endtask

	task automatic send_pixels(input int n, input bit fresh, input pattern_t pat,
			input int bubble_pct);
		rbb_pkg::in_item_t it;
		for (int i = 0; i < n; i++) begin
			it = make_pixel(pat, i);
			it.frame_start = fresh && (i == 0);
			if ($urandom_range(99) < bubble_pct) it.cmd = CMD_FLUSH;
			send_item(it);
		end
	endtask

	// Flush bubbles carry random channel data, which must be ignored
	task automatic send_flush(input int n);
		rbb_pkg::in_item_t it;
		for (int i = 0; i < n; i++) begin
			it = make_pixel(PAT_RANDOM, i);
			it.cmd = CMD_FLUSH;
			send_item(it);
		end
	endtask

	task automatic send_frame(input int cols, input int rows, input pattern_t pat);
		send_pixels(cols * rows, 1'b1, pat, 0);
		send_flush(cols + 1);
	endtask

	// Stop offering, wait for every predicted pixel, then let the pipeline settle
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input rbb_pkg::cfg_reg_t idx,
			input logic [rbb_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == rbb_pkg::REG_IMAGE_WIDTH) cfg_width = val[rbb_pkg::WIDTH_W-1:0];
		else cfg_height = val[rbb_pkg::HEIGHT_W-1:0];
		@(posedge clk);
	endtask

	task automatic configure(input logic [rbb_pkg::CFG_DATA_W-1:0] width_val,
			input logic [rbb_pkg::CFG_DATA_W-1:0] height_val);
		wait_drain();
		write_reg(rbb_pkg::REG_IMAGE_WIDTH, width_val);
		write_reg(rbb_pkg::REG_IMAGE_HEIGHT, height_val);
	endtask

	// Reset geometry (640 wide): first row of a frame comes out after the line delay
	task automatic test_reset_values();
		send_pixels(650, 1'b1, PAT_RANDOM, 0);
		wait_drain();
	endtask

	// Saturated and alternating channels through a 3x3 frame
	task automatic test_pixel_extremes();
		configure(3, 3);
		send_frame(3, 3, PAT_MAX);
		send_frame(3, 3, PAT_ALT);
	endtask

	// Widths 0, 1 and 2, height 1, and height 0 (no output at all)
	task automatic test_narrow_frames();
		configure(0, 3);
		send_frame(1, 3, PAT_RANDOM);
		configure(1, 2);
		send_frame(1, 2, PAT_ALT);
		configure(16'hf002, 4);
		send_frame(2, 4, PAT_RANDOM);
		configure(5, 1);
		send_frame(5, 1, PAT_RANDOM);
		configure(3, 0);
		send_frame(3, 3, PAT_RANDOM);
	endtask

	// Widest line of the random phases (two full rows fill every line entry they use),
	// then an oversized width that is capped and never fills the line delay here
	task automatic test_wide_frames();
		configure(64, 2);
		send_frame(64, 2, PAT_RANDOM);
		configure(16'h0fff, 3);
		send_pixels(20, 1'b1, PAT_RANDOM, 0);
	endtask

	// Largest height: a single column, far from the frame end
	task automatic test_tall_frame();
		configure(1, 16'hffff);
		send_pixels(24, 1'b1, PAT_RANDOM, 0);
	endtask

	// Restarts, items past the frame end, bubbles mid-frame, geometry changed mid-frame
	task automatic test_irregular_frames();
		configure(5, 4);
		send_pixels(12, 1'b1, PAT_RANDOM, 0);
		send_frame(5, 4, PAT_RANDOM);
		send_pixels(7, 1'b0, PAT_RANDOM, 25);
		send_pixels(20, 1'b1, PAT_RANDOM, 30);
		send_flush(6);
		configure(8, 5);
		send_pixels(21, 1'b1, PAT_RANDOM, 0);
		// narrower line while counters sit past the new width
		wait_drain();
		write_reg(rbb_pkg::REG_IMAGE_WIDTH, 4);
		send_pixels(10, 1'b0, PAT_RANDOM, 0);
		wait_drain();
		write_reg(rbb_pkg::REG_IMAGE_HEIGHT, 3);
		send_pixels(10, 1'b0, PAT_RANDOM, 0);
		send_flush(5);
	endtask

	// Receiver holds off long enough to back the block up into its input
	task automatic test_backpressure();
		configure(8, 6);
		hold_left <= 300;
		send_pixels(30, 1'b1, PAT_RANDOM, 0);
		// sender pauses mid-frame until the output catches up
		wait_drain();
		send_pixels(18, 1'b0, PAT_RANDOM, 0);
		send_flush(9);
	endtask

	task automatic test_random_frames(input int idle_pct, input int stall_cut, input int quota);
		int first;
		int sel;
		int cols;
		int rows;
		first           = items_sent;
		sender_idle_pct = idle_pct;
		stall_pct       = stall_cut;
		while (items_sent - first < quota) begin
			sel  = $urandom_range(19);
			cols = (sel < 14) ? $urandom_range(1, 6) :
				(sel < 19) ? $urandom_range(7, 24) : $urandom_range(25, 64);
			rows = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
			// upper data bits are outside the width register
			configure(rbb_pkg::CFG_DATA_W'(($urandom_range(15) << rbb_pkg::WIDTH_W) | cols),
				rbb_pkg::CFG_DATA_W'(rows));
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(9))
					0: send_pixels($urandom_range(1, cols * (rows + 1)), 1'b1, PAT_RANDOM, 0);
					1: begin
						send_pixels(cols * rows, 1'b1, PAT_RANDOM, 20);
						send_flush(cols + 1);
					end
					2: begin
						send_frame(cols, rows, PAT_RANDOM);
						send_pixels($urandom_range(1, cols + 3), 1'b0, PAT_RANDOM, 10);
					end
					3: begin
						send_pixels(cols * rows, 1'b0, PAT_RANDOM, 0);
						send_flush(cols + 1);
					end
					default: send_frame(cols, rows, PAT_RANDOM);
				endcase
			end
		end
	endtask

	// Receiver: long hold-off when requested, random stalls otherwise
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Compare each accepted output pixel with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_pixels.size() == 0) begin
				report_mismatch("output pixel with none predicted");
			end else begin
				want = pending_pixels.pop_front();
				if (out_data.red_out !== want.red_out)
					report_mismatch($sformatf("red %0h, expected %0h",
						out_data.red_out, want.red_out));
				if (out_data.green_out !== want.green_out)
					report_mismatch($sformatf("green %0h, expected %0h",
						out_data.green_out, want.green_out));
				if (out_data.blue_out !== want.blue_out)
					report_mismatch($sformatf("blue %0h, expected %0h",
						out_data.blue_out, want.blue_out));
				if (out_data.filtered !== want.filtered)
					report_mismatch($sformatf("filtered %b, expected %b",
						out_data.filtered, want.filtered));
				if (out_data.frame_end !== want.frame_end)
					report_mismatch($sformatf("frame_end %b, expected %b",
						out_data.frame_end, want.frame_end));
			end
		end
	end

	// Watchdog: too long without any handshake or register write
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < MAX_W; i++) line_mem[i] = '0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) win[c][r] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_pixel_extremes();
		test_narrow_frames();
		test_wide_frames();
		test_tall_frame();
		test_irregular_frames();
		test_backpressure();
		test_random_frames(0, 0, 50);
		test_random_frames(83, 0, 50);
		test_random_frames(0, 83, 50);
		test_random_frames(7, 7, 50);
		wait_drain();
		if (mismatch_count == 0 && pending_pixels.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### rgb_box_blur_3x3.f
hdl/rbb_pkg.sv
hdl/rbb_ram.sv
hdl/rbb_ctrl.sv
hdl/rbb_window.sv
hdl/rbb_mean.sv
hdl/rgb_box_blur_3x3.sv
test/rgb_box_blur_3x3_tb.sv
